/* rtl/core/sis_pkg.sv */
// shared types for the stable insertion sorter
package sis_pkg;

  // sequencer modes: collect items, then drain the sorted run
  typedef enum logic {
    ST_LOAD  = 1'b0,
    ST_DRAIN = 1'b1
  } sis_state_t;

  // per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic insert;  // place the broadcast item, larger entries move up one cell
    logic drain;   // every cell takes its upper neighbor, cell 0 leaves the chain
  } cell_ctrl_t;

endpackage

/* rtl/core/sis_stream_ifs.sv */
// valid/ready channel interfaces for the sorter input and result streams
interface sis_in_if #(
  parameter int RATING_BITS = 16,
  parameter int TAG_BITS    = 8
);
  logic                          valid;
  logic                          ready;
  logic signed [RATING_BITS-1:0] rating;
  logic        [TAG_BITS-1:0]    tag;
  logic                          last;

  modport source (output valid, rating, tag, last, input ready);
  modport sink   (input valid, rating, tag, last, output ready);
endinterface

interface sis_out_if #(
  parameter int RATING_BITS = 16,
  parameter int TAG_BITS    = 8
);
  logic                          valid;
  logic                          ready;
  logic signed [RATING_BITS-1:0] sorted_rating;
  logic        [TAG_BITS-1:0]    sorted_tag;
  logic                          final_res;
  logic                          overflow;

  modport source (output valid, sorted_rating, sorted_tag, final_res, overflow, input ready);
  modport sink   (input valid, sorted_rating, sorted_tag, final_res, overflow, output ready);
endinterface

/* rtl/core/sis_cell.sv */
// one slot of the sorted chain: holds an entry and trades it with its neighbors
module sis_cell #(
  parameter int RATING_BITS = 16,
  parameter int TAG_BITS    = 8
) (
  input  logic                          clk,
  input  sis_pkg::cell_ctrl_t           ctrl,
  input  logic                          occ,          // this slot holds an entry
  input  logic                          prev_occ,     // lower slot holds an entry
  input  logic                          prev_gt,      // lower slot is greater than the key
  input  logic signed [RATING_BITS-1:0] prev_rating,
  input  logic        [TAG_BITS-1:0]    prev_tag,
  input  logic signed [RATING_BITS-1:0] next_rating,
  input  logic        [TAG_BITS-1:0]    next_tag,
  input  logic signed [RATING_BITS-1:0] key_rating,
  input  logic        [TAG_BITS-1:0]    key_tag,
  output logic                          gt,
  output logic signed [RATING_BITS-1:0] rating,
  output logic        [TAG_BITS-1:0]    tag
);

  logic signed [RATING_BITS-1:0] rating_r, rating_nxt;
  logic        [TAG_BITS-1:0]    tag_r, tag_nxt;

  // strictly greater keeps equal ratings ahead of the new item
  assign gt = occ && (rating_r > key_rating);

  // slot update: shift up, take the new item, shift down, or hold
  always_comb begin
    rating_nxt = rating_r;
    tag_nxt    = tag_r;
    if (ctrl.insert) begin
      if (prev_gt) begin
        rating_nxt = prev_rating;
        tag_nxt    = prev_tag;
      end else if (prev_occ && (gt || !occ)) begin
        rating_nxt = key_rating;
        tag_nxt    = key_tag;
      end
    end else if (ctrl.drain) begin
      rating_nxt = next_rating;
      tag_nxt    = next_tag;
    end
  end

  // entry storage, no reset needed
  always_ff @(posedge clk) begin
    rating_r <= rating_nxt;
    tag_r    <= tag_nxt;
  end

  assign rating = rating_r;
  assign tag    = tag_r;

endmodule

/* rtl/core/stable_insertion_sorter_top.sv */
// top level: chain of sorting cells with load/drain sequencer
//
//  channel   | dir | handshake        | payload
//  ----------+-----+------------------+------------------------------------------
//  in_ch     | in  | valid / ready    | rating, tag, last
//  out_ch    | out | valid / ready    | sorted_rating, sorted_tag, final_res, overflow
//
// One item is taken per cycle while loading; every cell compares against the
// broadcast key and the chain opens a gap in that same cycle.
// After an item with last, the run leaves one result per cycle from cell 0 while
// out_ch is ready; no input is taken until the run is out.
// Output stalls simply hold the chain. Synchronous active-low reset empties
// the store; no clearing pass is needed.
module stable_insertion_sorter_top #(
  parameter int CAPACITY    = 32,
  parameter int RATING_BITS = 16,
  parameter int TAG_BITS    = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  sis_in_if.sink    in_ch,
  sis_out_if.source out_ch
);

  localparam int FILL_BITS = $clog2(CAPACITY + 1);

  sis_pkg::sis_state_t state_r, state_nxt;
  logic [FILL_BITS-1:0] fill_r, fill_nxt;
  logic                 dropped_r, dropped_nxt;

  sis_pkg::cell_ctrl_t  ctrl;
  logic                 in_xfer;
  logic                 out_xfer;
  logic                 full;
  logic                 in_rdy;
  logic                 out_vld;

  logic                          occ    [CAPACITY];
  logic                          gt     [CAPACITY];
  logic signed [RATING_BITS-1:0] rating [CAPACITY];
  logic        [TAG_BITS-1:0]    tag    [CAPACITY];

  // handshake decode
  assign in_xfer  = in_ch.valid && in_rdy;
  assign out_xfer = out_vld && out_ch.ready;
  assign full     = (fill_r == FILL_BITS'(CAPACITY));

  assign ctrl.insert = in_xfer && !full;
  assign ctrl.drain  = out_xfer;

  // chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign occ[i] = (FILL_BITS'(i) < fill_r);

    if (i == 0) begin : g_first
      sis_cell #(.RATING_BITS(RATING_BITS), .TAG_BITS(TAG_BITS)) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .occ        (occ[i]),
        .prev_occ   (1'b1),
        .prev_gt    (1'b0),
        .prev_rating(in_ch.rating),
        .prev_tag   (in_ch.tag),
        .next_rating(rating[i+1]),
        .next_tag   (tag[i+1]),
        .key_rating (in_ch.rating),
        .key_tag    (in_ch.tag),
        .gt         (gt[i]),
        .rating     (rating[i]),
        .tag        (tag[i])
      );
    end else if (i == CAPACITY - 1) begin : g_last
      sis_cell #(.RATING_BITS(RATING_BITS), .TAG_BITS(TAG_BITS)) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .occ        (occ[i]),
        .prev_occ   (occ[i-1]),
        .prev_gt    (gt[i-1]),
        .prev_rating(rating[i-1]),
        .prev_tag   (tag[i-1]),
        .next_rating(rating[i]),
        .next_tag   (tag[i]),
        .key_rating (in_ch.rating),
        .key_tag    (in_ch.tag),
        .gt         (gt[i]),
        .rating     (rating[i]),
        .tag        (tag[i])
      );
    end else begin : g_mid
      sis_cell #(.RATING_BITS(RATING_BITS), .TAG_BITS(TAG_BITS)) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .occ        (occ[i]),
        .prev_occ   (occ[i-1]),
        .prev_gt    (gt[i-1]),
        .prev_rating(rating[i-1]),
        .prev_tag   (tag[i-1]),
        .next_rating(rating[i+1]),
        .next_tag   (tag[i+1]),
        .key_rating (in_ch.rating),
        .key_tag    (in_ch.tag),
        .gt         (gt[i]),
        .rating     (rating[i]),
        .tag        (tag[i])
      );
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sis_pkg::ST_LOAD: begin
        if (in_xfer && in_ch.last) state_nxt = sis_pkg::ST_DRAIN;
      end
      sis_pkg::ST_DRAIN: begin
        if (out_xfer && (fill_r == FILL_BITS'(1))) state_nxt = sis_pkg::ST_LOAD;
      end
      default: state_nxt = sis_pkg::ST_LOAD;
    endcase
  end

  // state outputs
  always_comb begin
    in_rdy  = 1'b0;
    out_vld = 1'b0;
    case (state_r)
      sis_pkg::ST_LOAD:  in_rdy  = 1'b1;
      sis_pkg::ST_DRAIN: out_vld = 1'b1;
      default: begin
        in_rdy  = 1'b0;
        out_vld = 1'b0;
      end
    endcase
  end

  // fill count and overflow flag
  always_comb begin
    fill_nxt    = fill_r;
    dropped_nxt = dropped_r;
    if (ctrl.insert) fill_nxt = fill_r + FILL_BITS'(1);
    else if (ctrl.drain) fill_nxt = fill_r - FILL_BITS'(1);
    if (in_xfer && full) dropped_nxt = 1'b1;
    else if (out_xfer && (fill_r == FILL_BITS'(1))) dropped_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= sis_pkg::ST_LOAD;
      fill_r    <= '0;
      dropped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  // result channel driven straight from the bottom cell
  assign in_ch.ready          = in_rdy;
  assign out_ch.valid         = out_vld;
  assign out_ch.sorted_rating = rating[0];
  assign out_ch.sorted_tag    = tag[0];
  assign out_ch.final_res     = (fill_r == FILL_BITS'(1));
  assign out_ch.overflow      = dropped_r;

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_BITS'(CAPACITY))
    else $error("fill count above capacity");

  a_modes_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_rdy && out_vld))
    else $error("input and output open together");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld |-> (fill_r != '0))
    else $error("draining an empty chain");

  a_last_starts_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_ch.last) |=> out_vld)
    else $error("run not emitted after last item");

  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && out_ch.final_res) |=> (in_rdy && (fill_r == '0) && !dropped_r))
    else $error("store not cleared after final result");

endmodule
